// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL.
// Each macro expands to one labeled concurrent assertion on a rising clock
// edge, disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/teq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event queue package
// Sizes, status codes, controller/datapath interface types and the ring
// address helper of the time-ordered event queue.
// ----------------------------------------------------------------------------
package teq_pkg;

    // Queue geometry and field widths.
    localparam int QUEUE_DEPTH = 16;
    localparam int TIME_WIDTH  = 32;
    localparam int TAG_WIDTH   = 16;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W       = 5;
    localparam int STATUS_W    = 2;
    localparam int ENTRY_W     = TIME_WIDTH + TAG_WIDTH;

    // Stream payload layout.
    localparam int IN_DATA_W   = ((ENTRY_W + 7) / 8) * 8;
    localparam int OUT_BITS    = ENTRY_W + OCC_W;
    localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;
    localparam int OCC_LSB     = ENTRY_W;

    // Operation selected by the input item's tuser bit.
    localparam logic MODE_INSERT  = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_EXTRACTED = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } teq_status_t;

    // Read address source for the slot memory.
    typedef enum logic [1:0] {
        RD_HEAD = 2'd0,
        RD_TAIL = 2'd1,
        RD_POS  = 2'd2
    } teq_rd_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic        latch_in;
        teq_rd_sel_t rd_sel;
        logic        shift;
        logic        write_new;
        logic        ext_take;
        logic        res_load;
        teq_status_t res_status;
        logic        load_out;
    } teq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic less;
        logic pos_one;
        logic out_free;
    } teq_flag_t;

    // Physical slot of logical position lidx in the ring starting at head.
    function automatic logic [ADDR_W-1:0] teq_phys(input logic [ADDR_W-1:0] head,
                                                   input logic [CNT_W-1:0]  lidx);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(lidx);
        if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
            sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

// ----- rtl/core/teq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module teq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/teq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event queue controller
// Sequences insert walks, extracts and result hand-off over the datapath.
// ----------------------------------------------------------------------------
module teq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              in_mode,
    input  teq_pkg::teq_flag_t flags,
    output teq_pkg::teq_cmd_t  cmd
);
    import teq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_WRITE,
        S_EXT_TAKE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and datapath commands.
    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.rd_sel     = RD_HEAD;
        cmd.res_status = ST_INSERTED;
        unique case (state_reg)
            S_IDLE: begin
                // Prefetch the head for an extract or the tail for an insert.
                cmd.rd_sel = (in_mode == MODE_EXTRACT) ? RD_HEAD : RD_TAIL;
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    if (in_mode == MODE_INSERT) begin
                        if (flags.full) begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_FULL;
                            state_next     = S_DONE;
                        end else if (flags.empty) begin
                            state_next = S_INS_WRITE;
                        end else begin
                            state_next = S_INS_CMP;
                        end
                    end else begin
                        if (flags.empty) begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_EMPTY;
                            state_next     = S_DONE;
                        end else begin
                            state_next = S_EXT_TAKE;
                        end
                    end
                end
            end
            S_INS_CMP: begin
                // Move each later entry up one slot until the new time fits.
                cmd.rd_sel = RD_POS;
                if (flags.less) begin
                    cmd.shift = 1'b1;
                    if (flags.pos_one) begin
                        state_next = S_INS_WRITE;
                    end
                end else begin
                    state_next = S_INS_WRITE;
                end
            end
            S_INS_WRITE: begin
                cmd.write_new  = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_INSERTED;
                state_next     = S_DONE;
            end
            S_EXT_TAKE: begin
                cmd.ext_take   = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_EXTRACTED;
                state_next     = S_DONE;
            end
            S_DONE: begin
                if (flags.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

// ----- rtl/core/teq_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event queue datapath
// Ring-organized slot memory, head and count, insert walk pointer, result
// registers and the output register stage.
// ----------------------------------------------------------------------------
module teq_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [teq_pkg::TIME_WIDTH-1:0]      in_time,
    input  logic [teq_pkg::TAG_WIDTH-1:0]       in_tag,
    input  teq_pkg::teq_cmd_t                   cmd,
    output teq_pkg::teq_flag_t                  flags,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [teq_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic [teq_pkg::STATUS_W-1:0]        m_tuser
);
    import teq_pkg::*;

    logic [ADDR_W-1:0]     head_reg,  head_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      pos_reg,   pos_next;
    logic [TIME_WIDTH-1:0] time_reg;
    logic [TAG_WIDTH-1:0]  tag_reg;
    teq_status_t           res_status_reg;
    logic [TIME_WIDTH-1:0] res_time_reg;
    logic [TAG_WIDTH-1:0]  res_tag_reg;
    logic                  m_valid_reg;
    teq_status_t           out_status_reg;
    logic [TIME_WIDTH-1:0] out_time_reg;
    logic [TAG_WIDTH-1:0]  out_tag_reg;
    logic [OCC_W-1:0]      out_occ_reg;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [ENTRY_W-1:0]    mem_wdata;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [ENTRY_W-1:0]    mem_rdata;
    logic [TIME_WIDTH-1:0] rd_time;
    logic [TAG_WIDTH-1:0]  rd_tag;
    logic [CNT_W-1:0]      rd_lidx;

    assign rd_time = mem_rdata[TIME_WIDTH-1:0];
    assign rd_tag  = mem_rdata[ENTRY_W-1:TIME_WIDTH];

    // Walk pointer: starts at the fill level and steps down on each shift.
    always_comb begin
        priority if (cmd.latch_in) begin
            pos_next = count_reg;
        end else if (cmd.shift) begin
            pos_next = pos_reg - CNT_W'(1);
        end else begin
            pos_next = pos_reg;
        end
    end

    // Read address: head, last held entry, or the entry below the pointer.
    always_comb begin
        unique case (cmd.rd_sel)
            RD_TAIL: rd_lidx = (count_reg == '0) ? '0 : count_reg - CNT_W'(1);
            RD_POS:  rd_lidx = (pos_next == '0) ? '0 : pos_next - CNT_W'(1);
            default: rd_lidx = '0;
        endcase
        mem_raddr = teq_phys(head_reg, rd_lidx);
    end

    // Write port: a shifted entry or the new event, both at the pointer slot.
    always_comb begin
        mem_we    = cmd.shift | cmd.write_new;
        mem_waddr = teq_phys(head_reg, pos_reg);
        mem_wdata = cmd.shift ? mem_rdata : {tag_reg, time_reg};
    end

    teq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Head and fill level.
    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.ext_take) begin
            head_next  = (head_reg == ADDR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                : head_reg + ADDR_W'(1);
            count_next = count_reg - CNT_W'(1);
        end else if (cmd.write_new) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: pending item, result and output stage.
    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        if (cmd.latch_in) begin
            time_reg <= in_time;
            tag_reg  <= in_tag;
        end
        if (cmd.res_load) begin
            res_status_reg <= cmd.res_status;
            res_time_reg   <= cmd.ext_take ? rd_time : '0;
            res_tag_reg    <= cmd.ext_take ? rd_tag : '0;
        end
        if (cmd.load_out) begin
            out_status_reg <= res_status_reg;
            out_time_reg   <= res_time_reg;
            out_tag_reg    <= res_tag_reg;
            out_occ_reg    <= OCC_W'(count_reg);
        end
    end

    // Status toward the controller.
    assign flags.full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign flags.empty    = (count_reg == '0);
    assign flags.less     = (time_reg < rd_time);
    assign flags.pos_one  = (pos_reg == CNT_W'(1));
    assign flags.out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = OUT_DATA_W'({out_occ_reg, out_tag_reg, out_time_reg});

endmodule

// ----- rtl/core/time_ordered_event_queue_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-ordered event queue
// Stable sorted event queue: inserts keep ascending time order with equal
// times in arrival order; extracts return the earliest event.
// ----------------------------------------------------------------------------
// The queue holds up to QUEUE_DEPTH events in a ring-organized slot memory
// and works on one item at a time; each item returns one result item. The
// insert walk moves each held event with a later time than the new one up
// one slot per cycle through the memory's single write port, and a final
// compare finds the entry that stays. An insert that lands at the head
// (every held event is later, or the queue is empty) needs no such compare.
// A finished result moves into an output register and the next item can be
// accepted in the following cycle while that result waits for the consumer;
// a result only moves there once the one before it has been taken.
module time_ordered_event_queue_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input items.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [teq_pkg::IN_DATA_W-1:0]  s_tdata,  // event_time, event_tag
    input  logic                           s_tuser,  // mode
    // Result items.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [teq_pkg::OUT_DATA_W-1:0] m_tdata,  // out_time, out_tag, occupancy, zero pad
    output logic [teq_pkg::STATUS_W-1:0]   m_tuser   // status
);
    import teq_pkg::*;

    teq_cmd_t              cmd;
    teq_flag_t             flags;
    logic [TIME_WIDTH-1:0] in_time;
    logic [TAG_WIDTH-1:0]  in_tag;
    logic [OCC_W-1:0]      occ;
    logic                  out_full;
    logic                  out_empty;
    logic                  occ_full;
    logic                  in_accept;

    // Unpack the input item.
    assign in_time = s_tdata[TIME_WIDTH-1:0];
    assign in_tag  = s_tdata[ENTRY_W-1:TIME_WIDTH];

    teq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_mode  (s_tuser),
        .flags    (flags),
        .cmd      (cmd)
    );

    teq_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_time  (in_time),
        .in_tag   (in_tag),
        .cmd      (cmd),
        .flags    (flags),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Terms watched by the checks below.
    assign occ       = m_tdata[OCC_LSB +: OCC_W];
    assign out_full  = m_tvalid && (m_tuser == ST_FULL);
    assign out_empty = m_tvalid && (m_tuser == ST_EMPTY);
    assign occ_full  = (occ == OCC_W'(QUEUE_DEPTH));
    assign in_accept = s_tvalid && s_tready;

`include "assert_macros.svh"

    // A dropped insert is only reported when every slot is in use.
    `ASSERT_IMPLIES(a_full_occ, aclk, aresetn, out_full, occ_full, "full with free slots")

    // An empty report always comes with zero occupancy.
    `ASSERT_IMPLIES(a_empty_occ, aclk, aresetn, out_empty, occ == '0, "empty with held events")

    // Items are worked on one at a time.
    `ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, in_accept, !s_tready, "item taken while busy")

endmodule
